// ===== rtl/byte_ring_fifo_overflow_policy_macros.svh =====
// assertion macros used by the byte ring fifo datapath
`ifndef BYTE_RING_FIFO_OVERFLOW_POLICY_MACROS_SVH
`define BYTE_RING_FIFO_OVERFLOW_POLICY_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BRFOP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BRFOP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/brfop_pkg.sv =====
// shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps
package brfop_pkg;

  localparam int unsigned FIFO_DEPTH     = 1024;
  localparam int unsigned DROP_CAP       = 512;
  localparam int unsigned READ_BURST_MAX = 64;

  localparam int unsigned PTR_W     = $clog2(FIFO_DEPTH);
  localparam int unsigned PTRX_W    = PTR_W + 1;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned LIMIT_W   = 7;
  localparam int unsigned LEVEL_W   = 10;
  localparam int unsigned CTR_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = LEVEL_W;
  localparam int unsigned BURST_W   = $clog2(READ_BURST_MAX + 1);
  localparam int unsigned CALC_W    = ((PTRX_W > LEN_W) ? PTRX_W : LEN_W) + 1;

  // drop amount never exceeds the committed count, so cap it below the depth
  localparam int unsigned DROP_LIM  = (DROP_CAP < FIFO_DEPTH) ? DROP_CAP : FIFO_DEPTH - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WARN   = CFG_IDX_W'(1);

  localparam logic [LEVEL_W-1:0] WARN_RESET = LEVEL_W'(768);

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_QUERY = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_WARN = 2'd1,
    STAT_OVF  = 2'd2
  } status_e;

  typedef struct packed {
    logic ld_item;
    logic eval;
    logic wdata;
    logic rsetup;
    logic rstream;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  burst_zero;
    logic  burst_last;
  } dp_stat_t;

endpackage

// ===== rtl/brfop_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module brfop_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/brfop_ctrl.sv =====
// sequencing state machine for the byte ring fifo
`timescale 1ns / 1ps
module brfop_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  brfop_pkg::dp_stat_t stat_i,
  output brfop_pkg::dp_cmd_t  cmd_o,
  output logic                busy_o,
  output logic                res_valid_o,
  output logic                res_last_o,
  output logic                byte_valid_o
);
  import brfop_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EXEC    = 5'b00010,
    S_WDATA   = 5'b00100,
    S_RSTREAM = 5'b01000,
    S_EMIT    = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (stat_i.func)
          FUNC_WRITE: state_d = S_WDATA;
          FUNC_READ:  state_d = stat_i.burst_zero ? S_EMIT : S_RSTREAM;
          default:    state_d = S_EMIT;
        endcase
      end
      S_WDATA:   state_d = S_EMIT;
      S_RSTREAM: begin
        if (stat_i.burst_last) state_d = S_IDLE;
      end
      S_EMIT:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.ld_item = accept;
    cmd_o.eval    = (state_q == S_EXEC) && (stat_i.func == FUNC_WRITE);
    cmd_o.rsetup  = (state_q == S_EXEC) && (stat_i.func == FUNC_READ);
    cmd_o.clear   = (state_q == S_EXEC) && (stat_i.func == FUNC_CLEAR);
    cmd_o.wdata   = (state_q == S_WDATA);
    cmd_o.rstream = (state_q == S_RSTREAM);
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_valid_o  = (state_q == S_EMIT) || (state_q == S_RSTREAM);
  assign res_last_o   = (state_q == S_EMIT) || stat_i.burst_last;
  assign byte_valid_o = (state_q == S_RSTREAM);

endmodule

// ===== rtl/brfop_dp.sv =====
// pointers, counters, packet admission and byte store of the ring fifo
`timescale 1ns / 1ps
`include "byte_ring_fifo_overflow_policy_macros.svh"
module brfop_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  brfop_pkg::dp_cmd_t                  cmd_i,
  output brfop_pkg::dp_stat_t                 stat_o,
  input  logic                                cfg_we_i,
  input  logic [brfop_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [brfop_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [1:0]                          func_i,
  input  logic [brfop_pkg::BYTE_W-1:0]        data_byte_i,
  input  logic                                first_of_packet_i,
  input  logic [brfop_pkg::LEN_W-1:0]         packet_length_i,
  input  logic [brfop_pkg::LIMIT_W-1:0]       read_limit_i,
  output logic [brfop_pkg::BYTE_W-1:0]        out_byte_o,
  output logic                                packet_accepted_o,
  output logic [brfop_pkg::LEVEL_W-1:0]       used_count_o,
  output logic [brfop_pkg::LEVEL_W-1:0]       free_count_o,
  output logic [1:0]                          status_code_o,
  output logic [brfop_pkg::CTR_W-1:0]         overflows_seen_o,
  output logic [brfop_pkg::CTR_W-1:0]         bytes_dropped_o
);
  import brfop_pkg::*;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                input logic [PTR_W-1:0] n);
    logic [PTRX_W-1:0] sum;
    sum = {1'b0, p} + {1'b0, n};
    if (sum >= PTRX_W'(FIFO_DEPTH)) sum = sum - PTRX_W'(FIFO_DEPTH);
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_dist(input logic [PTR_W-1:0] wp,
                                                 input logic [PTR_W-1:0] rp);
    logic [PTRX_W-1:0] d;
    if (wp >= rp) d = {1'b0, wp} - {1'b0, rp};
    else          d = {1'b0, wp} + PTRX_W'(FIFO_DEPTH) - {1'b0, rp};
    return d[PTR_W-1:0];
  endfunction

  // latched item
  func_e              func_q;
  logic [BYTE_W-1:0]  data_q;
  logic               first_q;
  logic [LEN_W-1:0]   len_q;
  logic [LIMIT_W-1:0] limit_q;

  // fifo state
  logic [PTR_W-1:0]   wp_q, rp_q, pend_q, raddr_q;
  logic [LEN_W-1:0]   remain_q;
  logic               adm_q, acc_q;
  logic [CTR_W-1:0]   ovf_q, drop_q;
  logic [BURST_W-1:0] burst_q;
  logic               policy_q;
  logic [LEVEL_W-1:0] warn_q;

  logic [PTR_W-1:0]   used, free;
  logic [CALC_W-1:0]  len_c, avail_c, short_c, need_c;
  logic [PTR_W-1:0]   need_p;
  logic               in_range, no_fit, full_len, refit;
  logic [BURST_W-1:0] lim_c, burst_n;

  logic               ram_we, ram_re;
  logic [PTR_W-1:0]   ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  assign used = ring_dist(wp_q, rp_q);
  assign free = PTR_W'(FIFO_DEPTH - 1) - used;

  // admission check for a packet head
  always_comb begin
    len_c    = CALC_W'(len_q);
    avail_c  = CALC_W'(free);
    short_c  = len_c - avail_c;
    need_c   = (short_c > CALC_W'(DROP_LIM)) ? CALC_W'(DROP_LIM) : short_c;
    need_p   = need_c[PTR_W-1:0];
    in_range = (len_q != '0) && (len_c <= CALC_W'(FIFO_DEPTH));
    no_fit   = len_c > avail_c;
    full_len = len_c == CALC_W'(FIFO_DEPTH);
    refit    = len_c <= (avail_c + need_c);
  end

  // burst length of a read request
  always_comb begin
    if (CALC_W'(limit_q) > CALC_W'(READ_BURST_MAX)) lim_c = BURST_W'(READ_BURST_MAX);
    else                                            lim_c = BURST_W'(limit_q);
    if (CALC_W'(used) < CALC_W'(lim_c)) burst_n = BURST_W'(used);
    else                                burst_n = lim_c;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      func_q  <= func_e'(func_i);
      data_q  <= data_byte_i;
      first_q <= first_of_packet_i;
      len_q   <= packet_length_i;
      limit_q <= read_limit_i;
    end
    if (cmd_i.rsetup) begin
      raddr_q <= ring_add(rp_q, PTR_W'(1));
    end else if (cmd_i.rstream) begin
      raddr_q <= ring_add(raddr_q, PTR_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      pend_q   <= '0;
      remain_q <= '0;
      adm_q    <= 1'b0;
      acc_q    <= 1'b0;
      ovf_q    <= '0;
      drop_q   <= '0;
      burst_q  <= '0;
      policy_q <= 1'b0;
      warn_q   <= WARN_RESET;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_POLICY) policy_q <= cfg_data_i[0];
        if (cfg_index_i == CFG_WARN)   warn_q   <= cfg_data_i[LEVEL_W-1:0];
      end
      if (cmd_i.ld_item) begin
        acc_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        wp_q     <= '0;
        rp_q     <= '0;
        pend_q   <= '0;
        remain_q <= '0;
        adm_q    <= 1'b0;
        ovf_q    <= '0;
      end
      if (cmd_i.eval && first_q) begin
        adm_q    <= 1'b0;
        remain_q <= len_q;
        if (in_range) begin
          if (no_fit) begin
            ovf_q <= ovf_q + CTR_W'(1);
            if (!full_len && policy_q) begin
              rp_q   <= ring_add(rp_q, need_p);
              drop_q <= drop_q + CTR_W'(need_p);
              if (refit) begin
                adm_q  <= 1'b1;
                pend_q <= wp_q;
              end
            end
          end else begin
            adm_q  <= 1'b1;
            pend_q <= wp_q;
          end
        end
      end
      if (cmd_i.wdata && (remain_q != '0)) begin
        acc_q    <= adm_q;
        remain_q <= remain_q - LEN_W'(1);
        if (adm_q) pend_q <= ring_add(pend_q, PTR_W'(1));
        // last byte commits the packet
        if (remain_q == LEN_W'(1)) begin
          adm_q <= 1'b0;
          if (adm_q) wp_q <= ring_add(pend_q, PTR_W'(1));
        end
      end
      if (cmd_i.rsetup) begin
        burst_q <= burst_n;
        rp_q    <= ring_add(rp_q, PTR_W'(burst_n));
      end else if (cmd_i.rstream) begin
        burst_q <= burst_q - BURST_W'(1);
      end
    end
  end

  assign ram_we    = cmd_i.wdata && (remain_q != '0) && adm_q;
  assign ram_re    = cmd_i.rsetup || cmd_i.rstream;
  assign ram_raddr = cmd_i.rsetup ? rp_q : raddr_q;

  brfop_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pend_q),
    .wdata_i(data_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign stat_o.func       = func_q;
  assign stat_o.burst_zero = (burst_n == '0);
  assign stat_o.burst_last = cmd_i.rstream && (burst_q == BURST_W'(1));

  always_comb begin
    if (CALC_W'(used) >= CALC_W'(warn_q)) status_code_o = STAT_WARN;
    else if (ovf_q != '0)                 status_code_o = STAT_OVF;
    else                                  status_code_o = STAT_OK;
  end

  assign out_byte_o        = cmd_i.rstream ? ram_rdata : '0;
  assign packet_accepted_o = acc_q;
  assign used_count_o      = LEVEL_W'(used);
  assign free_count_o      = LEVEL_W'(free);
  assign overflows_seen_o  = ovf_q;
  assign bytes_dropped_o   = drop_q;

  `BRFOP_ASSERT_IMP(a_adm_has_bytes, clk_i, rst_ni, adm_q, remain_q != '0, "admitted packet with no bytes left")
  `BRFOP_ASSERT_IMP(a_stream_nonzero, clk_i, rst_ni, cmd_i.rstream, burst_q != '0, "read stream with empty burst count")
  `BRFOP_ASSERT_NXT(a_read_used, clk_i, rst_ni, cmd_i.rsetup && (burst_n != '0), used == ($past(used) - PTR_W'($past(burst_n))), "read burst did not retire its bytes")

endmodule

// ===== rtl/byte_ring_fifo_overflow_policy.sv =====
// top level of the byte ring fifo with packet admission and overflow policy
`timescale 1ns / 1ps
// usage:
//   command channel: an item is taken at a clock edge with start_i high and
//   busy_o low. func_i selects write byte, read request, clear or status query.
//   write packets arrive one byte per item; the first byte carries the length,
//   and the packet is admitted or rejected as a whole right then
//   result channel: each result sits on the result ports for one cycle, marked
//   by result_valid_o; last_result_o flags the final result of an item. the
//   receiver cannot stall, so results must be sampled when they appear
//   config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 policy, 1
//   warning level) and cfg_data_i; always ready, write only while idle
//   timing: a write passes through exec, data and result states, its result in
//   the result state. clear, query and an empty read go from exec straight to the
//   result state. a read of n bytes gives its first byte in the state after exec and
//   one byte per cycle after that, with no separate result state. the single
//   byte-store read port sets the one byte per cycle
//   reset: pointers, counters and policy clear, warning level goes to 768.
//   the byte store is not cleared; only written bytes are ever read back
module byte_ring_fifo_overflow_policy (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // command channel
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         func_i,
  input  logic [brfop_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                               first_of_packet_i,
  input  logic [brfop_pkg::LEN_W-1:0]        packet_length_i,
  input  logic [brfop_pkg::LIMIT_W-1:0]      read_limit_i,
  // config channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [brfop_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [brfop_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // result channel
  output logic                               result_valid_o,
  output logic [brfop_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                               byte_valid_o,
  output logic                               last_result_o,
  output logic                               packet_accepted_o,
  output logic [brfop_pkg::LEVEL_W-1:0]      used_count_o,
  output logic [brfop_pkg::LEVEL_W-1:0]      free_count_o,
  output logic [1:0]                         status_code_o,
  output logic [brfop_pkg::CTR_W-1:0]        overflows_seen_o,
  output logic [brfop_pkg::CTR_W-1:0]        bytes_dropped_o
);
  import brfop_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_we;

  // config writes are registered as soon as they are valid, so the port never pushes back
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // controller walks each item through exec and then its write-data, read-stream or result steps
  brfop_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .res_valid_o (result_valid_o),
    .res_last_o  (last_result_o),
    .byte_valid_o(byte_valid_o)
  );

  // datapath holds pointers, counters, config and the byte store
  brfop_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (func_i),
    .data_byte_i      (data_byte_i),
    .first_of_packet_i(first_of_packet_i),
    .packet_length_i  (packet_length_i),
    .read_limit_i     (read_limit_i),
    .out_byte_o       (out_byte_o),
    .packet_accepted_o(packet_accepted_o),
    .used_count_o     (used_count_o),
    .free_count_o     (free_count_o),
    .status_code_o    (status_code_o),
    .overflows_seen_o (overflows_seen_o),
    .bytes_dropped_o  (bytes_dropped_o)
  );

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the byte ring fifo with packet admission and overflow policy
`timescale 1ns / 1ps
module tb;
  import brfop_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;      // quiet time before a config write / the end
  localparam int unsigned CYCLE_LIMIT   = 400000; // far above the slowest legal run
  localparam int unsigned GAP_MAX       = 14;
  localparam int unsigned TAIL_OPS      = 24;     // last ops go out back to back

  // one command on the item channel
  typedef struct packed {
    func_e               func;
    logic [BYTE_W-1:0]   data;
    logic                first;
    logic [LEN_W-1:0]    len;
    logic [LIMIT_W-1:0]  limit;
  } ring_cmd_t;

  // one result as the block reports it
  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic                last;
    logic                accepted;
    logic [LEVEL_W-1:0]  used;
    logic [LEVEL_W-1:0]  free;
    logic [1:0]          status;
    logic [CTR_W-1:0]    overflows;
    logic [CTR_W-1:0]    dropped;
  } ring_reply_t;

  // what the driver pulls off its list: a command, a register write, or a wait for quiet
  typedef enum logic [1:0] {
    OP_ITEM,
    OP_CFG,
    OP_SYNC
  } ring_op_kind_e;

  typedef struct packed {
    ring_op_kind_e            kind;
    ring_cmd_t                cmd;
    logic [CFG_IDX_W-1:0]     cfg_idx;
    logic [CFG_DATA_W-1:0]    cfg_val;
  } ring_op_t;

  // dut signals, all known from time zero
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  logic [1:0]              func_i = FUNC_QUERY;
  logic [BYTE_W-1:0]       data_byte_i = '0;
  logic                    first_of_packet_i = 1'b0;
  logic [LEN_W-1:0]        packet_length_i = '0;
  logic [LIMIT_W-1:0]      read_limit_i = '0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = CFG_POLICY;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                    result_valid_o;
  logic [BYTE_W-1:0]       out_byte_o;
  logic                    byte_valid_o;
  logic                    last_result_o;
  logic                    packet_accepted_o;
  logic [LEVEL_W-1:0]      used_count_o;
  logic [LEVEL_W-1:0]      free_count_o;
  logic [1:0]              status_code_o;
  logic [CTR_W-1:0]        overflows_seen_o;
  logic [CTR_W-1:0]        bytes_dropped_o;

  byte_ring_fifo_overflow_policy u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .func_i            (func_i),
    .data_byte_i       (data_byte_i),
    .first_of_packet_i (first_of_packet_i),
    .packet_length_i   (packet_length_i),
    .read_limit_i      (read_limit_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .result_valid_o    (result_valid_o),
    .out_byte_o        (out_byte_o),
    .byte_valid_o      (byte_valid_o),
    .last_result_o     (last_result_o),
    .packet_accepted_o (packet_accepted_o),
    .used_count_o      (used_count_o),
    .free_count_o      (free_count_o),
    .status_code_o     (status_code_o),
    .overflows_seen_o  (overflows_seen_o),
    .bytes_dropped_o   (bytes_dropped_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the fifo: store, pointers, in-flight packet, counters, registers
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]  ring_mem [0:FIFO_DEPTH-1];
  logic [PTR_W-1:0]   ring_wp = '0;
  logic [PTR_W-1:0]   ring_rp = '0;
  logic [PTR_W-1:0]   ring_pp = '0;       // where the in-flight packet writes next
  logic [LEN_W-1:0]   ring_remaining = '0;
  logic               ring_admitted = 1'b0;
  logic [CTR_W-1:0]   ring_ovf = '0;
  logic [CTR_W-1:0]   ring_drop = '0;
  logic               ring_policy = 1'b0;
  logic [LEVEL_W-1:0] ring_warn = WARN_RESET;

  ring_reply_t ring_replies_q[$];   // results still owed by the block, oldest first
  ring_op_t    ring_ops_q[$];       // commands and register writes not yet driven

  int unsigned mismatch_cnt = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_read_bytes = 0;
  int unsigned n_cfg = 0;
  int unsigned n_admitted = 0;
  int unsigned n_overflow_events = 0;

  // committed bytes; the 10-bit difference wraps exactly like the ring
  function automatic logic [LEVEL_W-1:0] ring_used();
    return ring_wp - ring_rp;
  endfunction

  function automatic logic [LEVEL_W-1:0] ring_free();
    return LEVEL_W'(FIFO_DEPTH - 1) - ring_used();
  endfunction

  // queue one result, taking the occupancy view after the whole item took effect
  function automatic void ring_reply(logic [BYTE_W-1:0] b, logic v, logic l, logic a);
    ring_reply_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.last       = l;
    r.accepted   = a;
    r.used       = ring_used();
    r.free       = ring_free();
    // warning outranks overflow
    if (r.used >= ring_warn)
      r.status = STAT_WARN;
    else if (ring_ovf != '0)
      r.status = STAT_OVF;
    else
      r.status = STAT_OK;
    r.overflows  = ring_ovf;
    r.dropped    = ring_drop;
    ring_replies_q.push_back(r);
  endfunction

  // admission decision taken on the first byte of a packet
  function automatic void ring_open_packet(logic [LEN_W-1:0] len);
    int unsigned avail;
    int unsigned need;
    ring_admitted  = 1'b0;
    ring_remaining = len;
    // zero or oversized lengths: rejected silently, bytes still counted down
    if (len == 0 || len > FIFO_DEPTH)
      return;
    avail = ring_free();
    if (len > avail) begin
      ring_ovf++;
      n_overflow_events++;
      // a full-depth packet can never fit, so nothing is sacrificed for it
      if (len == FIFO_DEPTH || !ring_policy)
        return;
      need = len - avail;
      if (need > DROP_CAP)
        need = DROP_CAP;
      ring_rp   = ring_rp + PTR_W'(need);
      ring_drop = ring_drop + CTR_W'(need);
      // capped drop may still leave too little room; the drop stands anyway
      if (len > ring_free())
        return;
    end
    ring_admitted = 1'b1;
    ring_pp       = ring_wp;
    n_admitted++;
  endfunction

  function automatic void ring_apply_op(ring_cmd_t c);
    int unsigned n;
    int unsigned lim;
    logic [PTR_W-1:0] rd;
    logic acc;
    case (c.func)
      FUNC_WRITE: begin
        if (c.first)
          ring_open_packet(c.len);
        if (ring_remaining == 0) begin
          // stray byte with no packet open
          ring_reply('0, 1'b0, 1'b1, 1'b0);
        end else begin
          acc = ring_admitted;
          if (acc) begin
            ring_mem[ring_pp] = c.data;
            ring_pp++;
          end
          ring_remaining--;
          // last byte: the packet becomes visible to readers
          if (ring_remaining == 0) begin
            if (acc)
              ring_wp = ring_pp;
            ring_admitted = 1'b0;
          end
          ring_reply('0, 1'b0, 1'b1, acc);
        end
      end
      FUNC_READ: begin
        lim = (c.limit > READ_BURST_MAX) ? READ_BURST_MAX : c.limit;
        n   = ring_used();
        if (n > lim)
          n = lim;
        if (n == 0) begin
          ring_reply('0, 1'b0, 1'b1, 1'b0);
        end else begin
          rd      = ring_rp;
          ring_rp = ring_rp + PTR_W'(n);
          for (int unsigned i = 0; i < n; i++) begin
            ring_reply(ring_mem[rd], 1'b1, (i + 1 == n), 1'b0);
            rd++;
          end
          n_read_bytes += n;
        end
      end
      FUNC_CLEAR: begin
        // dropped byte total survives a clear
        ring_wp        = '0;
        ring_rp        = '0;
        ring_pp        = '0;
        ring_remaining = '0;
        ring_admitted  = 1'b0;
        ring_ovf       = '0;
        ring_reply('0, 1'b0, 1'b1, 1'b0);
      end
      default: begin
        ring_reply('0, 1'b0, 1'b1, 1'b0);
      end
    endcase
  endfunction

  function automatic void ring_apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_POLICY)
      ring_policy = val[0];
    else if (idx == CFG_WARN)
      ring_warn = val[LEVEL_W-1:0];
    n_cfg++;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus list builders
  // ---------------------------------------------------------------------------
  // fields a command does not use still get random values so their bits toggle
  function automatic ring_cmd_t any_cmd(func_e f);
    ring_cmd_t c;
    c.func  = f;
    c.data  = BYTE_W'($urandom);
    c.first = 1'($urandom_range(0, 1));
    c.len   = LEN_W'($urandom);
    c.limit = LIMIT_W'($urandom);
    return c;
  endfunction

  function automatic void queue_cmd(ring_cmd_t c);
    ring_op_t op;
    op         = '0;
    op.kind    = OP_ITEM;
    op.cmd     = c;
    ring_ops_q.push_back(op);
  endfunction

  function automatic void queue_write(logic first, int unsigned len, logic [BYTE_W-1:0] d);
    ring_cmd_t c;
    c       = any_cmd(FUNC_WRITE);
    c.first = first;
    c.len   = LEN_W'(len);
    c.data  = d;
    queue_cmd(c);
  endfunction

  // first byte announces len; only sent bytes go out, a short one is left in flight
  function automatic void queue_packet(int unsigned len, int unsigned sent);
    queue_write(1'b1, len, BYTE_W'($urandom));
    for (int unsigned i = 1; i < sent; i++)
      queue_write(1'b0, $urandom, BYTE_W'($urandom));
  endfunction

  function automatic void queue_read(int unsigned lim);
    ring_cmd_t c;
    c       = any_cmd(FUNC_READ);
    c.limit = LIMIT_W'(lim);
    queue_cmd(c);
  endfunction

  // register writes only after every owed result is in and the block has settled
  function automatic void queue_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    ring_op_t op;
    op         = '0;
    op.kind    = OP_SYNC;
    ring_ops_q.push_back(op);
    op.kind    = OP_CFG;
    op.cfg_idx = idx;
    op.cfg_val = CFG_DATA_W'(val);
    ring_ops_q.push_back(op);
  endfunction

  // mostly well-formed packets and reads with random content, some noise on top
  function automatic void queue_random_phase(int unsigned n);
    int unsigned cnt;
    int unsigned pick;
    int unsigned len;
    int unsigned sent;
    cnt = 0;
    while (cnt < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 9) == 0) begin
          // huge length: overflow probe, abandoned after a few bytes
          len  = $urandom_range(900, 1023);
          sent = $urandom_range(1, 4);
        end else if ($urandom_range(0, 7) == 0) begin
          len  = $urandom_range(30, 120);
          sent = len;
        end else begin
          len  = $urandom_range(1, 12);
          sent = len;
        end
        // now and then a packet is cut short and overtaken by the next one
        if ($urandom_range(0, 9) == 0)
          sent = $urandom_range(1, len);
        queue_packet(len, sent);
        cnt += sent;
      end else if (pick < 85) begin
        queue_read(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64));
        cnt++;
      end else if (pick < 92) begin
        queue_cmd(any_cmd(FUNC_QUERY));
        cnt++;
      end else if (pick < 95) begin
        queue_cmd(any_cmd(FUNC_CLEAR));
        cnt++;
      end else if (pick < 98) begin
        // lone byte: lands in an unfinished packet or is ignored
        queue_write(1'b0, $urandom, BYTE_W'($urandom));
      end else begin
        // illegal or never-fitting lengths
        case ($urandom_range(0, 2))
          0:       len = 0;
          1:       len = FIFO_DEPTH;
          default: len = $urandom_range(FIFO_DEPTH + 1, 2047);
        endcase
        queue_write(1'b1, len, BYTE_W'($urandom));
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: pulls from ring_ops_q, holds start/cfg_valid until taken, idles in bursts
  // ---------------------------------------------------------------------------
  logic        replies_drained = 1'b1;  // registered by the monitor from its queue state
  int unsigned gap_cnt = 0;
  int unsigned calm_cnt = 0;

  always @(posedge clk_i) begin
    logic     go_start;
    logic     go_cfg;
    ring_op_t op;
    go_start = start_i;
    go_cfg   = cfg_valid_i;
    if (!rst_ni) begin
      go_start = 1'b0;
      go_cfg   = 1'b0;
    end else begin
      if (start_i && !busy_o)
        go_start = 1'b0;
      if (cfg_valid_i && cfg_ready_o)
        go_cfg = 1'b0;
      if (!go_start && !go_cfg) begin
        if (gap_cnt != 0) begin
          gap_cnt--;
        end else if (ring_ops_q.size() != 0) begin
          op = ring_ops_q[0];
          case (op.kind)
            OP_ITEM: begin
              void'(ring_ops_q.pop_front());
              go_start          = 1'b1;
              func_i            <= op.cmd.func;
              data_byte_i       <= op.cmd.data;
              first_of_packet_i <= op.cmd.first;
              packet_length_i   <= op.cmd.len;
              read_limit_i      <= op.cmd.limit;
              // idle after this item is taken; calm stretches and the tail stay busy
              if (ring_ops_q.size() > TAIL_OPS) begin
                if (calm_cnt != 0)
                  calm_cnt--;
                else if ($urandom_range(0, 15) == 0)
                  calm_cnt = $urandom_range(10, 30);
                else if ($urandom_range(0, 2) == 0)
                  gap_cnt = $urandom_range(1, GAP_MAX);
              end
            end
            OP_CFG: begin
              void'(ring_ops_q.pop_front());
              go_cfg      = 1'b1;
              cfg_index_i <= op.cfg_idx;
              cfg_data_i  <= op.cfg_val;
            end
            default: begin
              // wait for quiet, then let the block settle
              if (!start_i && replies_drained) begin
                void'(ring_ops_q.pop_front());
                gap_cnt = SETTLE_CYCLES;
              end
            end
          endcase
        end
      end
    end
    start_i     <= go_start;
    cfg_valid_i <= go_cfg;
  end

  // ---------------------------------------------------------------------------
  // monitor: check each strobed result, then update the shadow fifo from the edge's handshakes
  // ---------------------------------------------------------------------------
  function automatic void chk(string fname, logic [CTR_W-1:0] want, logic [CTR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    ring_reply_t want;
    ring_cmd_t   c;
    if (rst_ni) begin
      // results never belong to an item taken at the same edge, so check first
      if (result_valid_o === 1'b1) begin
        if (ring_replies_q.size() == 0) begin
          $error("result with nothing outstanding: out_byte %0h last %0b",
                 out_byte_o, last_result_o);
          mismatch_cnt++;
        end else begin
          want = ring_replies_q.pop_front();
          n_results++;
          chk("out_byte",        want.out_byte,   out_byte_o);
          chk("byte_valid",      want.byte_valid, byte_valid_o);
          chk("last_result",     want.last,       last_result_o);
          chk("packet_accepted", want.accepted,   packet_accepted_o);
          chk("used_count",      want.used,       used_count_o);
          chk("free_count",      want.free,       free_count_o);
          chk("status_code",     want.status,     status_code_o);
          chk("overflows_seen",  want.overflows,  overflows_seen_o);
          chk("bytes_dropped",   want.dropped,    bytes_dropped_o);
        end
      end
      if (start_i && !busy_o) begin
        c.func  = func_e'(func_i);
        c.data  = data_byte_i;
        c.first = first_of_packet_i;
        c.len   = packet_length_i;
        c.limit = read_limit_i;
        ring_apply_op(c);
        n_items++;
      end
      if (cfg_valid_i && cfg_ready_o)
        ring_apply_cfg(cfg_index_i, cfg_data_i);
      replies_drained <= (ring_replies_q.size() == 0);
    end
  end

  // watchdog
  int unsigned cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    // directed corner cases, run with the reset register values
    queue_cmd(any_cmd(FUNC_QUERY));
    queue_read(0);                          // empty fifo, zero limit
    queue_write(1'b0, 5, 8'hFF);            // byte with no packet open
    queue_write(1'b1, 3, 8'h00);
    queue_write(1'b0, 0, 8'hFF);
    queue_write(1'b0, 2047, 8'h5A);
    queue_read(127);                        // limit above the burst cap
    queue_read(1);                          // empty again
    queue_write(1'b1, 0, 8'h11);            // zero length
    queue_write(1'b0, 1, 8'h22);
    queue_write(1'b1, 2047, 8'h33);         // far above depth
    queue_write(1'b1, FIFO_DEPTH + 1, 8'h44);
    queue_write(1'b1, FIFO_DEPTH, 8'h55);   // full depth: overflow, never admitted
    queue_packet(5, 2);                     // overtaken by the next first byte
    queue_packet(2, 2);
    queue_read(READ_BURST_MAX);
    queue_cmd(any_cmd(FUNC_CLEAR));
    queue_packet(FIFO_DEPTH - 1, 1);        // largest packet that fits an empty fifo
    queue_packet(1, 1);
    queue_read(READ_BURST_MAX);

    // partial fill under drop-oldest: full depth rejected, then a partial drop that fits
    queue_cfg(CFG_POLICY, 1);
    queue_cfg(CFG_WARN, 60);
    queue_packet(80, 80);
    queue_write(1'b1, FIFO_DEPTH, 8'h0F);   // full depth: no drop even under this policy
    queue_write(1'b0, 0, 8'h3C);            // bytes of a rejected packet are discarded
    queue_read(READ_BURST_MAX);
    queue_packet(1020, 3);                  // small drop makes it fit
    queue_cmd(any_cmd(FUNC_CLEAR));         // abandons it, dropped total kept
    queue_read(READ_BURST_MAX);

    // random phases across register settings, extremes first
    queue_cfg(CFG_POLICY, 1);
    queue_cfg(CFG_WARN, 0);
    queue_random_phase(35);
    queue_cfg(CFG_POLICY, 0);
    queue_cfg(CFG_WARN, 1023);
    queue_random_phase(35);
    queue_cfg(CFG_POLICY, 1);
    queue_cfg(CFG_WARN, $urandom_range(0, 1023));
    queue_random_phase(35);
    queue_cfg(CFG_POLICY, 0);
    queue_cfg(CFG_WARN, $urandom_range(100, 600));
    queue_random_phase(35);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ring_ops_q.size() != 0 || start_i || cfg_valid_i || !replies_drained)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (ring_replies_q.size() != 0) begin
      $error("%0d results never arrived", ring_replies_q.size());
      mismatch_cnt++;
    end

    $display("summary: %0d items in, %0d results checked, %0d bytes read back, %0d register writes",
             n_items, n_results, n_read_bytes, n_cfg);
    $display("summary: %0d packets admitted, %0d overflow events, %0d bytes dropped in total",
             n_admitted, n_overflow_events, ring_drop);
    if (mismatch_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
